[rtl/rpc_pkg.sv]
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types, constants and tables of the rectangular/polar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rpc_pkg;

    localparam int DATA_WIDTH   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int FRAC         = 8;
    localparam int XW           = 27;
    localparam int ZW           = 32;
    localparam int IDX_W        = 4;
    localparam int GW           = 30;
    localparam int PW           = XW + GW;

    localparam logic [2:0] FN_SET_REAL = 3'd0;
    localparam logic [2:0] FN_SET_IMAG = 3'd1;
    localparam logic [2:0] FN_SET_RECT = 3'd2;
    localparam logic [2:0] FN_SET_MAG  = 3'd3;
    localparam logic [2:0] FN_SET_ANG  = 3'd4;
    localparam logic [2:0] FN_SET_POL  = 3'd5;
    localparam logic [2:0] FN_READ     = 3'd6;

    typedef logic signed [XW-1:0] rpc_dp_t;
    typedef logic signed [ZW-1:0] rpc_ang_t;

    typedef struct packed {
        logic [2:0]                   func;
        logic signed [DATA_WIDTH-1:0] real_in;
        logic signed [DATA_WIDTH-1:0] imag_in;
        logic [DATA_WIDTH-1:0]        magnitude_in;
        logic signed [DATA_WIDTH-1:0] angle_in;
    } rpc_request_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] real_out;
        logic signed [DATA_WIDTH-1:0] imag_out;
        logic [DATA_WIDTH-1:0]        magnitude_out;
        logic signed [DATA_WIDTH-1:0] angle_out;
    } rpc_result_t;

    typedef struct packed {
        logic             ccw;
        logic [IDX_W-1:0] shift;
    } rpc_rot_ctrl_t;

    function automatic rpc_ang_t atan_at(input logic [IDX_W-1:0] idx);
        rpc_ang_t val;
        case (idx)
            4'd0:    val = 32'sd536870912;
            4'd1:    val = 32'sd316933406;
            4'd2:    val = 32'sd167458907;
            4'd3:    val = 32'sd85004756;
            4'd4:    val = 32'sd42667331;
            4'd5:    val = 32'sd21354465;
            4'd6:    val = 32'sd10679838;
            4'd7:    val = 32'sd5340245;
            4'd8:    val = 32'sd2670163;
            4'd9:    val = 32'sd1335087;
            4'd10:   val = 32'sd667544;
            4'd11:   val = 32'sd333772;
            4'd12:   val = 32'sd166886;
            4'd13:   val = 32'sd83443;
            4'd14:   val = 32'sd41722;
            default: val = 32'sd20861;
        endcase
        return val;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_v;
        v     = v_in;
        res   = 64'd0;
        bit_v = 64'h4000_0000_0000_0000;
        for (int n = 0; n < 32; n++)
        begin
            if (bit_v > v)
            begin
                bit_v = bit_v >> 2;
            end
        end
        for (int n = 0; n < 32; n++)
        begin
            if (bit_v != 64'd0)
            begin
                if (v >= res + bit_v)
                begin
                    v   = v - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end
                else
                begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        return res;
    endfunction

    function automatic logic [63:0] calc_gain();
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] quo;
        p = 64'd1 << 30;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            p = p + (p >> (2 * i));
        end
        s = isqrt64(p << 30);
        if (s == 64'd0)
        begin
            s = 64'd1;
        end
        num = (64'd1 << 60) + (s >> 1);
        rem = 64'd0;
        quo = 64'd0;
        for (int k = 63; k >= 0; k--)
        begin
            rem = {rem[62:0], num[k]};
            if (rem >= s)
            begin
                rem    = rem - s;
                quo[k] = 1'b1;
            end
        end
        return quo;
    endfunction

    localparam logic [63:0]   GAIN_FULL = calc_gain();
    localparam logic [GW-1:0] GAIN_Q30  = GAIN_FULL[GW-1:0];

endpackage

`default_nettype wire

[rtl/rect_polar_converter.sv]
// ----------------------------------------------------------------------------
// rect_polar_converter
// Complex value held in rectangular and polar form, converted by CORDIC.
// ----------------------------------------------------------------------------
// Each request sets one or both rectangular parts, one or both polar parts,
// or reads, and returns all four stored values. An update makes sixteen
// passes through the single shift-add rotator, plus setup, one pass through
// the gain multiplier and rounding; a rectangular update with both parts
// zero skips these. req_ready is low while a request is being worked on.
// The result sits in an output register until taken; while an earlier
// result still waits there, the next request holds in its last cycle.
`default_nettype none

module rect_polar_converter
    import rpc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_ready,
    input  rpc_request_t req_data,
    output logic         res_valid,
    input  logic         res_ready,
    output rpc_result_t  res_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_VSETUP,
        S_RMUL,
        S_RSETUP,
        S_ITER,
        S_VMUL,
        S_VFIN,
        S_RFIN,
        S_DONE
    } state_t;

    typedef enum logic {
        MODE_VEC,
        MODE_ROT
    } mode_t;

    localparam rpc_ang_t HALF_PI = 32'sd1073741824;

    state_t                       state_reg,  state_next;
    mode_t                        mode_reg,   mode_next;
    logic [IDX_W-1:0]             iter_reg,   iter_next;
    rpc_dp_t                      x_reg,      x_next;
    rpc_dp_t                      y_reg,      y_next;
    rpc_ang_t                     z_reg,      z_next;
    logic [PW-1:0]                prod_reg,   prod_next;
    logic signed [DATA_WIDTH-1:0] real_reg,   real_next;
    logic signed [DATA_WIDTH-1:0] imag_reg,   imag_next;
    logic [DATA_WIDTH-1:0]        mag_reg,    mag_next;
    logic signed [DATA_WIDTH-1:0] ang_reg,    ang_next;
    logic                         rvalid_reg, rvalid_next;
    rpc_result_t                  res_reg,    res_next;

    rpc_rot_ctrl_t  rot_ctrl;
    rpc_dp_t        x_rot;
    rpc_dp_t        y_rot;
    rpc_ang_t       z_rot;
    logic [XW-1:0]  mul_op;
    logic [PW-1:0]  mul_prod;
    logic           accept;
    rpc_dp_t        re_ext;
    rpc_dp_t        im_ext;
    rpc_ang_t       z_start;
    logic [PW:0]    x0_sum;
    logic [PW:0]    mag_sum;
    logic [PW-38:0] mag_round;
    rpc_ang_t       z_round;

    function automatic logic signed [DATA_WIDTH-1:0] round_sat(input rpc_dp_t v);
        logic signed [XW:0] wide;
        logic [XW:0]        absv;
        logic [XW:0]        q;
        logic signed [XW+1:0] sr;
        wide = {v[XW-1], v};
        absv = wide[XW] ? (~wide + (XW+1)'(1)) : wide;
        q    = (absv + (XW+1)'(1 << (FRAC - 1))) >> FRAC;
        sr   = wide[XW] ? -signed'({1'b0, q}) : signed'({1'b0, q});
        if (sr > (XW+2)'(32767))
        begin
            return 16'sh7FFF;
        end
        else if (sr < -(XW+2)'(32768))
        begin
            return 16'sh8000;
        end
        return sr[DATA_WIDTH-1:0];
    endfunction

    rpc_rotator u_rotator (
        .x     (x_reg),
        .y     (y_reg),
        .z     (z_reg),
        .ctrl  (rot_ctrl),
        .x_rot (x_rot),
        .y_rot (y_rot),
        .z_rot (z_rot)
    );

    rpc_gain_mul u_gain_mul (
        .operand (mul_op),
        .product (mul_prod)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid & req_ready;
    assign res_valid = rvalid_reg;
    assign res_data  = res_reg;

    assign rot_ctrl.shift = iter_reg;
    assign rot_ctrl.ccw   = (mode_reg == MODE_VEC) ? y_reg[XW-1] : ~z_reg[ZW-1];

    assign mul_op = (mode_reg == MODE_ROT) ? XW'(mag_reg)
                  : (x_reg[XW-1] ? '0 : XW'(unsigned'(x_reg)));

    assign re_ext    = {{(XW-DATA_WIDTH-FRAC){real_reg[DATA_WIDTH-1]}}, real_reg, FRAC'(0)};
    assign im_ext    = {{(XW-DATA_WIDTH-FRAC){imag_reg[DATA_WIDTH-1]}}, imag_reg, FRAC'(0)};
    assign z_start   = {ang_reg, (ZW-DATA_WIDTH)'(0)};
    assign x0_sum    = (PW+1)'(prod_reg) + ((PW+1)'(1) << 21);
    assign mag_sum   = (PW+1)'(prod_reg) + ((PW+1)'(1) << 37);
    assign mag_round = mag_sum[PW:38];
    assign z_round   = z_reg + (32'sd1 <<< (ZW - DATA_WIDTH - 1));

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        iter_next   = iter_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        prod_next   = prod_reg;
        real_next   = real_reg;
        imag_next   = imag_reg;
        mag_next    = mag_reg;
        ang_next    = ang_reg;
        rvalid_next = rvalid_reg;
        res_next    = res_reg;

        if (rvalid_reg && res_ready)
        begin
            rvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    iter_next = '0;
                    unique case (req_data.func)
                        FN_SET_REAL:
                        begin
                            real_next  = req_data.real_in;
                            mode_next  = MODE_VEC;
                            state_next = S_VSETUP;
                        end
                        FN_SET_IMAG:
                        begin
                            imag_next  = req_data.imag_in;
                            mode_next  = MODE_VEC;
                            state_next = S_VSETUP;
                        end
                        FN_SET_RECT:
                        begin
                            real_next  = req_data.real_in;
                            imag_next  = req_data.imag_in;
                            mode_next  = MODE_VEC;
                            state_next = S_VSETUP;
                        end
                        FN_SET_MAG:
                        begin
                            mag_next   = req_data.magnitude_in;
                            mode_next  = MODE_ROT;
                            state_next = S_RMUL;
                        end
                        FN_SET_ANG:
                        begin
                            ang_next   = req_data.angle_in;
                            mode_next  = MODE_ROT;
                            state_next = S_RMUL;
                        end
                        FN_SET_POL:
                        begin
                            mag_next   = req_data.magnitude_in;
                            ang_next   = req_data.angle_in;
                            mode_next  = MODE_ROT;
                            state_next = S_RMUL;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_VSETUP:
            begin
                if (real_reg == '0 && imag_reg == '0)
                begin
                    mag_next   = '0;
                    ang_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    if (real_reg[DATA_WIDTH-1])
                    begin
                        x_next = -re_ext;
                        y_next = -im_ext;
                        z_next = {1'b1, (ZW-1)'(0)};
                    end
                    else
                    begin
                        x_next = re_ext;
                        y_next = im_ext;
                        z_next = '0;
                    end
                    state_next = S_ITER;
                end
            end

            S_RMUL:
            begin
                prod_next  = mul_prod;
                state_next = S_RSETUP;
            end

            S_RSETUP:
            begin
                y_next = '0;
                if (z_start > HALF_PI || z_start < -HALF_PI)
                begin
                    x_next = -rpc_dp_t'(x0_sum[XW+21:22]);
                    z_next = {~z_start[ZW-1], z_start[ZW-2:0]};
                end
                else
                begin
                    x_next = rpc_dp_t'(x0_sum[XW+21:22]);
                    z_next = z_start;
                end
                state_next = S_ITER;
            end

            S_ITER:
            begin
                x_next    = x_rot;
                y_next    = y_rot;
                z_next    = z_rot;
                iter_next = iter_reg + IDX_W'(1);
                if (iter_reg == IDX_W'(CORDIC_STEPS - 1))
                begin
                    state_next = (mode_reg == MODE_VEC) ? S_VMUL : S_RFIN;
                end
            end

            S_VMUL:
            begin
                prod_next  = mul_prod;
                state_next = S_VFIN;
            end

            S_VFIN:
            begin
                if (mag_round > (PW-37)'(16'hFFFF))
                begin
                    mag_next = 16'hFFFF;
                end
                else
                begin
                    mag_next = mag_round[DATA_WIDTH-1:0];
                end
                ang_next   = z_round[ZW-1:ZW-DATA_WIDTH];
                state_next = S_DONE;
            end

            S_RFIN:
            begin
                real_next  = round_sat(x_reg);
                imag_next  = round_sat(y_reg);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rvalid_reg || res_ready)
                begin
                    res_next.real_out      = real_reg;
                    res_next.imag_out      = imag_reg;
                    res_next.magnitude_out = mag_reg;
                    res_next.angle_out     = ang_reg;
                    rvalid_next            = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= MODE_VEC;
            iter_reg   <= '0;
            real_reg   <= '0;
            imag_reg   <= '0;
            mag_reg    <= '0;
            ang_reg    <= '0;
            rvalid_reg <= 1'b0;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            iter_reg   <= iter_next;
            real_reg   <= real_next;
            imag_reg   <= imag_next;
            mag_reg    <= mag_next;
            ang_reg    <= ang_next;
            rvalid_reg <= rvalid_next;
            res_reg    <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

[rtl/rpc_rotator.sv]
// ----------------------------------------------------------------------------
// rpc_rotator
// One CORDIC micro-rotation: shift-add on x and y, arctangent step on z.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_rotator
    import rpc_pkg::*;
(
    input  rpc_dp_t       x,
    input  rpc_dp_t       y,
    input  rpc_ang_t      z,
    input  rpc_rot_ctrl_t ctrl,
    output rpc_dp_t       x_rot,
    output rpc_dp_t       y_rot,
    output rpc_ang_t      z_rot
);

    rpc_dp_t  x_sh;
    rpc_dp_t  y_sh;
    rpc_ang_t step;

    assign x_sh = x >>> ctrl.shift;
    assign y_sh = y >>> ctrl.shift;
    assign step = atan_at(ctrl.shift);

    always_comb
    begin
        if (ctrl.ccw)
        begin
            x_rot = x - y_sh;
            y_rot = y + x_sh;
            z_rot = z - step;
        end
        else
        begin
            x_rot = x + y_sh;
            y_rot = y - x_sh;
            z_rot = z + step;
        end
    end

endmodule

`default_nettype wire

[rtl/rpc_gain_mul.sv]
// ----------------------------------------------------------------------------
// rpc_gain_mul
// Multiplier by the inverse of the CORDIC gain, in Q30.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_gain_mul
    import rpc_pkg::*;
(
    input  logic [XW-1:0] operand,
    output logic [PW-1:0] product
);

    assign product = PW'(operand) * PW'(GAIN_Q30);

endmodule

`default_nettype wire
